FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at an edge implies cons at the same edge
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rgbhsl_pkg.sv
// ---------------------------------------------------------------------------
// RGB to HSL package
// Output field widths, fixed-point scale constants and hue sector codes.
// ---------------------------------------------------------------------------
`default_nettype none

package rgbhsl_pkg;

  localparam int HUE_W       = 15;
  localparam int SAT_W       = 14;
  localparam int LIT_W       = 14;
  localparam int OUT_TDATA_W = 48;

  // quotient bits per divider lane
  localparam int DIV_Q_W = 15;

  localparam int unsigned HUE_FULL      = 23040;
  localparam int unsigned HUE_NUM_SCALE = 7680;
  localparam int unsigned SAT_NUM_SCALE = 25600;
  localparam int unsigned LIT_NUM_SCALE = 6400;
  localparam int unsigned PCT_FULL      = 12800;

  typedef enum logic [2:0] {
    SEC_RED      = 3'd0,
    SEC_GREEN    = 3'd2,
    SEC_BLUE     = 3'd4,
    SEC_RED_WRAP = 3'd6
  } sector_t;

endpackage

`default_nettype wire

FILE: rtl/core/rgbhsl_div.sv
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, most significant first. Each stage
// advances on its own enable so the lane follows the pipeline's stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module rgbhsl_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 9,
  parameter int Q_W   = 15
) (
  input  logic             clk,
  input  logic [Q_W-1:0]   en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] dvs,
  output logic [Q_W-1:0]   quo
);

  logic [NUM_W-1:0] rem_r [Q_W-1];
  logic [DEN_W-1:0] dvs_r [Q_W-1];
  logic [Q_W-1:0]   quo_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] dvs_in;
    logic [Q_W-1:0]   quo_in;
    logic [NUM_W-1:0] shifted;
    logic [Q_W-1:0]   quo_nxt;
    logic             fit;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign dvs_in = dvs;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dvs_in = dvs_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign shifted = NUM_W'(dvs_in) << (Q_W - 1 - k);
    assign fit     = (rem_in >= shifted);

    always_comb begin
      quo_nxt              = quo_in;
      quo_nxt[Q_W - 1 - k] = fit;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        quo_r[k] <= quo_nxt;
      end
    end

    if (k < Q_W - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k] <= fit ? (rem_in - shifted) : rem_in;
          dvs_r[k] <= dvs_in;
        end
      end
    end
  end

  assign quo = quo_r[Q_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/rgb_to_hsl_converter.sv
// ---------------------------------------------------------------------------
// RGB to HSL converter
// Converts one RGB pixel per beat into hue (1/64 degree), saturation and
// lightness (percent in 1/128 units), rounded to nearest.
//
//   Channel  Dir  Handshake            Payload
//   in_      in   in_tvalid/in_tready  red, green, blue (CHANNEL_BITS each)
//   out_     out  out_tvalid/out_tready hue[14:0], saturation, lightness
//
// One beat per cycle sustained while out_tready holds; three front stages
// (max/min, sector sum, scaling products), 15 divider stages, one output.
// The 15-bit quotient, one bit per stage, sets the depth; lightness takes a
// reciprocal product in the first of those stages and is delayed alongside.
// Reset clears all valid bits; payload registers are not reset.
// A stage advances whenever the stage after it is empty or advancing, so
// bubbles fill while the output waits and no beat is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rgb_to_hsl_converter #(
  parameter int CHANNEL_BITS = 8,
  localparam int IN_TDATA_W  = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // red, green, blue, zero pad
  input  logic [IN_TDATA_W-1:0]              in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hue[14:0], saturation[13:0], lightness[13:0], zero pad
  output logic [rgbhsl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import rgbhsl_pkg::*;

  localparam int CB     = CHANNEL_BITS;
  localparam int NUM_W  = CB + 16;
  localparam int DEN_W  = CB + 1;
  localparam int U_W    = CB + 3;
  localparam int STG_N  = 3 + DIV_Q_W + 1;
  localparam int ST_D0  = 3;
  localparam int ST_OUT = STG_N - 1;
  localparam int PAD_W  = OUT_TDATA_W - HUE_W - SAT_W - LIT_W;

  localparam int LX_W   = CB + 14;
  localparam int LM_W   = CB + 15;
  localparam int LP_W   = LX_W + LM_W;
  localparam int LIT_SH = 2 * CB + 14;

  localparam logic [CB-1:0] CH_FULL  = {CB{1'b1}};
  localparam logic [CB:0]   TWO_FULL = {CH_FULL, 1'b0};

  localparam longint unsigned LIT_DEN_L = (64'd1 << CB) - 64'd1;
  localparam longint unsigned LIT_M_L   =
    ((64'd1 << LIT_SH) + LIT_DEN_L - 64'd1) / LIT_DEN_L;
  localparam logic [LM_W-1:0] LIT_RECIP = LM_W'(LIT_M_L);

  // handshake chain
  logic [STG_N-1:0] vld_r;
  logic [STG_N-1:0] vld_nxt;
  logic [STG_N-1:0] rdy;

  always_comb begin
    rdy[ST_OUT] = !vld_r[ST_OUT] || out_tready;
    for (int i = STG_N - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = rdy[0] ? in_tvalid : vld_r[0];
    for (int i = 1; i < STG_N; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage A: max, min, delta, sector
  logic [CB-1:0] red, green, blue;
  logic          red_max, green_max, red_min, green_min;
  logic [CB-1:0] mx, mn, op_p, op_q;
  logic [CB-1:0] a_d_nxt, a_mag_nxt;
  logic [CB:0]   a_sum_nxt;
  logic          a_neg_nxt;
  sector_t       a_sec_nxt;

  logic [CB-1:0] a_d_r, a_mag_r;
  logic [CB:0]   a_sum_r;
  logic          a_neg_r;
  sector_t       a_sec_r;

  assign red   = in_tdata[CB-1:0];
  assign green = in_tdata[2*CB-1:CB];
  assign blue  = in_tdata[3*CB-1:2*CB];

  always_comb begin
    red_max   = (red >= green) && (red >= blue);
    green_max = !red_max && (green >= blue);
    red_min   = (red <= green) && (red <= blue);
    green_min = !red_min && (green <= blue);
    mx = red_max ? red : (green_max ? green : blue);
    mn = red_min ? red : (green_min ? green : blue);
    if (red_max) begin
      op_p = green;
      op_q = blue;
    end else if (green_max) begin
      op_p = blue;
      op_q = red;
    end else begin
      op_p = red;
      op_q = green;
    end
    a_neg_nxt = (op_p < op_q);
    a_mag_nxt = a_neg_nxt ? (op_q - op_p) : (op_p - op_q);
    a_d_nxt   = mx - mn;
    a_sum_nxt = {1'b0, mx} + {1'b0, mn};
    if (red_max) begin
      a_sec_nxt = a_neg_nxt ? SEC_RED_WRAP : SEC_RED;
    end else if (green_max) begin
      a_sec_nxt = SEC_GREEN;
    end else begin
      a_sec_nxt = SEC_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_d_r   <= a_d_nxt;
      a_mag_r <= a_mag_nxt;
      a_sum_r <= a_sum_nxt;
      a_neg_r <= a_neg_nxt;
      a_sec_r <= a_sec_nxt;
    end
  end

  // stage B: hue sector sum, saturation denominator
  logic [U_W-1:0] base;
  logic [U_W-1:0] b_u_nxt;
  logic [CB:0]    den_wide;
  logic [CB-1:0]  b_den_nxt;

  logic [U_W-1:0] b_u_r;
  logic [CB-1:0]  b_d_r, b_den_r;
  logic [CB:0]    b_sum_r;

  always_comb begin
    base     = U_W'(a_sec_r) * U_W'(a_d_r);
    b_u_nxt  = a_neg_r ? (base - U_W'(a_mag_r)) : (base + U_W'(a_mag_r));
    den_wide = (a_sum_r <= {1'b0, CH_FULL}) ? a_sum_r : (TWO_FULL - a_sum_r);
    b_den_nxt = den_wide[CB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      b_u_r   <= b_u_nxt;
      b_d_r   <= a_d_r;
      b_den_r <= b_den_nxt;
      b_sum_r <= a_sum_r;
    end
  end

  // stage C: rounding numerators and divisors
  logic [NUM_W-1:0] c_hue_num_r, c_sat_num_r;
  logic [LX_W-1:0]  c_lit_x_r;
  logic [DEN_W-1:0] c_hue_dvs_r, c_sat_dvs_r;
  logic             c_gray_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      c_hue_num_r <= NUM_W'(b_u_r) * NUM_W'(HUE_NUM_SCALE) + NUM_W'(b_d_r);
      c_sat_num_r <= NUM_W'(b_d_r) * NUM_W'(SAT_NUM_SCALE) + NUM_W'(b_den_r);
      c_lit_x_r   <= LX_W'(b_sum_r) * LX_W'(LIT_NUM_SCALE) + LX_W'(CH_FULL >> 1);
      c_hue_dvs_r <= {b_d_r, 1'b0};
      c_sat_dvs_r <= {b_den_r, 1'b0};
      c_gray_r    <= (b_d_r == '0);
    end
  end

  // divider lanes
  logic [DIV_Q_W-1:0] hue_q, sat_q;

  rgbhsl_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(DIV_Q_W)) u_hue_div (
    .clk (clk),
    .en  (rdy[ST_D0 +: DIV_Q_W]),
    .num (c_hue_num_r),
    .dvs (c_hue_dvs_r),
    .quo (hue_q)
  );

  rgbhsl_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(DIV_Q_W)) u_sat_div (
    .clk (clk),
    .en  (rdy[ST_D0 +: DIV_Q_W]),
    .num (c_sat_num_r),
    .dvs (c_sat_dvs_r),
    .quo (sat_q)
  );

  // lightness: divide by full scale through a reciprocal product, then delay
  logic [LP_W-1:0]  lit_prod;
  logic [LIT_W-1:0] lit_dly_r [DIV_Q_W];

  assign lit_prod = LP_W'(c_lit_x_r) * LP_W'(LIT_RECIP);

  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_lit
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rdy[ST_D0]) begin
          lit_dly_r[k] <= lit_prod[LIT_SH +: LIT_W];
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rdy[ST_D0 + k]) begin
          lit_dly_r[k] <= lit_dly_r[k-1];
        end
      end
    end
  end

  logic gray_r [DIV_Q_W];

  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_gray
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rdy[ST_D0]) begin
          gray_r[k] <= c_gray_r;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rdy[ST_D0 + k]) begin
          gray_r[k] <= gray_r[k-1];
        end
      end
    end
  end

  // output stage: wrap hue, zero hue and saturation of gray pixels
  logic [HUE_W-1:0] hue_nxt, hue_r;
  logic [SAT_W-1:0] sat_nxt, sat_r;
  logic [LIT_W-1:0] lit_nxt, lit_r;

  always_comb begin
    if (gray_r[DIV_Q_W-1]) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      hue_nxt = (hue_q >= HUE_W'(HUE_FULL)) ? (hue_q - HUE_W'(HUE_FULL)) : hue_q;
      sat_nxt = sat_q[SAT_W-1:0];
    end
    lit_nxt = lit_dly_r[DIV_Q_W-1];
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      lit_r <= lit_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[ST_OUT];
  assign out_tdata  = {{PAD_W{1'b0}}, lit_r, sat_r, hue_r};

  `ASSERT_IMPLIES(a_hue_range, clk, rst_n, out_tvalid, hue_r < HUE_W'(HUE_FULL),
                  "hue beyond 360 degrees")
  `ASSERT_IMPLIES(a_pct_range, clk, rst_n, out_tvalid,
                  (sat_r <= SAT_W'(PCT_FULL)) && (lit_r <= LIT_W'(PCT_FULL)),
                  "saturation or lightness beyond 100 percent")
  `ASSERT_IMPLIES(a_empty_out_ready, clk, rst_n, !out_tvalid, in_tready,
                  "input stalled while output stage is empty")

endmodule

`default_nettype wire
